// ===== rtl/sh128_pkg.sv =====
// Shared types, constants and SipRound half-step functions for the SipHash stream block.
package sh128_pkg;

	localparam logic [63:0] IV0 = 64'h736f6d6570736575;
	localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
	localparam logic [63:0] IV2 = 64'h6c7967656e657261;
	localparam logic [63:0] IV3 = 64'h7465646279746573;
	localparam logic [7:0]  FINAL_XOR = 8'hff;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		JOB_ABSORB,
		JOB_FINAL,
		JOB_WORD_FINAL
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  len;
		logic [63:0] word;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} lanes_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ABSORB,
		BK_FINALIZE,
		BK_EMIT
	} back_state_t;

	localparam lanes_t LANES_IV = '{v0: IV0, v1: IV1, v2: IV2, v3: IV3};

	function automatic lanes_t sip_half_a(lanes_t x);
		lanes_t      y;
		logic [63:0] s0;
		logic [63:0] s2;
		s0   = x.v0 + x.v1;
		s2   = x.v2 + x.v3;
		y.v0 = {s0[31:0], s0[63:32]};
		y.v1 = {x.v1[50:0], x.v1[63:51]} ^ s0;
		y.v2 = s2;
		y.v3 = {x.v3[47:0], x.v3[63:48]} ^ s2;
		return y;
	endfunction

	function automatic lanes_t sip_half_b(lanes_t x);
		lanes_t      y;
		logic [63:0] s0;
		logic [63:0] s2;
		s0   = x.v0 + x.v3;
		s2   = x.v2 + x.v1;
		y.v0 = s0;
		y.v3 = {x.v3[42:0], x.v3[63:43]} ^ s0;
		y.v1 = {x.v1[46:0], x.v1[63:47]} ^ s2;
		y.v2 = {s2[31:0], s2[63:32]};
		return y;
	endfunction

endpackage

// ===== rtl/sh128_front.sv =====
// Front end: takes byte transactions, packs words and issues absorb and final jobs.
module sh128_front import sh128_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        is_last,
	input  queue_stat_t q_stat,
	output logic        push,
	output job_t        push_job
);

	logic [55:0] pend_q;
	logic [7:0]  len_q;
	logic [55:0] pend_d;
	logic [7:0]  len_d;
	logic        accept;
	logic        word_done;
	logic [2:0]  pos;

	assign in_stall  = q_stat.full;
	assign accept    = in_valid & ~q_stat.full;
	assign pos       = len_q[2:0];
	assign word_done = byte_present & (pos == 3'd7);

	always_comb begin
		pend_d = pend_q;
		len_d  = len_q;
		if (byte_present) begin
			len_d = len_q + 8'd1;
			if (word_done) begin
				pend_d = '0;
			end else begin
				pend_d = pend_q | (56'(data_byte) << {pos, 3'b000});
			end
		end
	end

	always_comb begin
		push          = 1'b0;
		push_job.kind = JOB_ABSORB;
		push_job.len  = len_d;
		push_job.word = {data_byte, pend_q};
		if (accept) begin
			if (is_last) begin
				push = 1'b1;
				if (word_done) begin
					push_job.kind = JOB_WORD_FINAL;
				end else begin
					push_job.kind = JOB_FINAL;
					push_job.word = {len_d, pend_d};
				end
			end else if (word_done) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			len_q  <= '0;
		end else if (accept) begin
			if (is_last) begin
				pend_q <= '0;
				len_q  <= '0;
			end else begin
				pend_q <= pend_d;
				len_q  <= len_d;
			end
		end
	end

endmodule

// ===== rtl/sh128_queue.sv =====
// Job queue between the front end and the round engine.
module sh128_queue import sh128_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  job_t        push_job,
	input  logic        pop,
	output job_t        head_job,
	output queue_stat_t q_stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push & ~q_stat.full;
	assign do_pop       = pop & ~q_stat.empty;
	assign head_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/sh128_back.sv =====
// Round engine: runs half SipRounds per job and holds the result register.
module sh128_back import sh128_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t q_stat,
	input  job_t        head_job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_lo,
	output logic [63:0] hash_hi
);

	back_state_t state_q;
	back_state_t state_d;
	lanes_t      lanes_q;
	lanes_t      pre;
	lanes_t      post;
	logic [2:0]  cnt_q;
	logic [63:0] w_q;
	job_kind_t   kind_q;
	logic [7:0]  len_q;
	logic        out_valid_q;
	logic [63:0] hash_lo_q;
	logic [63:0] hash_hi_q;
	logic        out_free;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign hash_lo   = hash_lo_q;
	assign hash_hi   = hash_hi_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					state_d = BK_ABSORB;
				end
			end
			BK_ABSORB: begin
				if (cnt_q == 3'd3) begin
					case (kind_q)
						JOB_ABSORB:     state_d = BK_IDLE;
						JOB_WORD_FINAL: state_d = BK_ABSORB;
						default:        state_d = BK_FINALIZE;
					endcase
				end
			end
			BK_FINALIZE: begin
				if (cnt_q == 3'd7) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == BK_IDLE) & ~q_stat.empty;
		pre = lanes_q;
		if (state_q == BK_ABSORB && cnt_q == 3'd0) begin
			pre.v3 = lanes_q.v3 ^ w_q;
		end
		if (state_q == BK_FINALIZE && cnt_q == 3'd0) begin
			pre.v2 = lanes_q.v2 ^ 64'(FINAL_XOR);
		end
		post = cnt_q[0] ? sip_half_b(pre) : sip_half_a(pre);
		if (state_q == BK_ABSORB && cnt_q == 3'd3) begin
			post.v0 = post.v0 ^ w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			lanes_q     <= LANES_IV;
			cnt_q       <= '0;
			kind_q      <= JOB_ABSORB;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_IDLE: begin
					cnt_q <= '0;
					if (pop) begin
						kind_q <= head_job.kind;
					end
				end
				BK_ABSORB: begin
					lanes_q <= post;
					if (cnt_q == 3'd3) begin
						cnt_q <= '0;
						if (kind_q == JOB_WORD_FINAL) begin
							kind_q <= JOB_FINAL;
						end
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				BK_FINALIZE: begin
					lanes_q <= post;
					cnt_q   <= cnt_q + 3'd1;
				end
				BK_EMIT: begin
					if (out_free) begin
						lanes_q <= LANES_IV;
					end
				end
				default: cnt_q <= '0;
			endcase
			if (state_q == BK_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			w_q   <= head_job.word;
			len_q <= head_job.len;
		end else if (state_q == BK_ABSORB && cnt_q == 3'd3 && kind_q == JOB_WORD_FINAL) begin
			w_q <= {len_q, 56'd0};
		end
		if (state_q == BK_EMIT && out_free) begin
			hash_lo_q <= lanes_q.v0 ^ lanes_q.v1;
			hash_hi_q <= lanes_q.v2 ^ lanes_q.v3;
		end
	end

endmodule

// ===== rtl/siphash_128_stream_top.sv =====
// Top level of the keyless SipHash-2-4 byte stream hasher with a 128-bit result.
//
// Input channel: one transaction per message byte (data_byte, byte_present,
// is_last) on in_valid / in_stall. A transaction with byte_present low and
// is_last low is a no-op; is_last high ends the message, with or without a byte.
// Output channel: one transaction per message (hash_lo, hash_hi) on
// out_valid / out_stall.
// Throughput: one byte per cycle while in_stall is low. Every eighth byte costs
// the round engine a queue pop plus four half-round steps, so a byte stream alone
// does not fill the queue. A message end costs more: its absorb (twice when the
// last byte completes a word), finalization and emit; short messages back to
// back are bound by that. out_valid rises once the end job has been absorbed,
// finalized and emitted, after any queued work ahead of it.
// A 4-entry job queue parts the byte front end from the round engine; in_stall
// rises only when it is full. A stalled result holds in the output register
// and the engine waits behind it while the front keeps taking bytes until the queue fills.
// Reset clears the queue, the partial word and the length and loads the lanes with the IV.
module siphash_128_stream_top import sh128_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_lo,
	output logic [63:0] hash_hi
);

	queue_stat_t q_stat;
	logic        push;
	job_t        push_job;
	logic        pop;
	job_t        head_job;

	sh128_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.is_last      (is_last),
		.q_stat       (q_stat),
		.push         (push),
		.push_job     (push_job)
	);

	sh128_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	sh128_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hash_lo   (hash_lo),
		.hash_hi   (hash_hi)
	);

endmodule

// ===== rtl/sh128_checker.sv =====
// Port-level checker for the SipHash stream block and its bind.
module sh128_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        is_last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] hash_lo,
	input logic [63:0] hash_hi
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hash_lo) && $stable(hash_hi))
		else $error("result payload changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(is_last))
		else $error("input transaction changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind siphash_128_stream_top sh128_checker u_sh128_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.is_last   (is_last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hash_lo   (hash_lo),
	.hash_hi   (hash_hi)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the SipHash-2-4 byte stream hasher with a 128-bit result.
module testbench;

	localparam logic [63:0] LANE0_INIT = 64'h736f6d6570736575;
	localparam logic [63:0] LANE1_INIT = 64'h646f72616e646f6d;
	localparam logic [63:0] LANE2_INIT = 64'h6c7967656e657261;
	localparam logic [63:0] LANE3_INIT = 64'h7465646279746573;
	localparam logic [63:0] FINISH_XOR = 64'h00000000000000ff;
	localparam int          ITEM_TARGET = 650;
	localparam int          MAX_SHOWN = 10;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sip_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} stream_item_t;

	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] hash_lo;
	logic [63:0] hash_hi;

	stream_item_t stim_q[$];
	digest_t      digest_q[$];
	stream_item_t drv_item;
	digest_t      got_digest;
	digest_t      want_digest;

	sip_state_t  lanes;
	logic [55:0] tail_word;
	logic [7:0]  msg_len;

	int          load_count = 0;
	int          tx_count = 0;
	int          digests_checked = 0;
	int          err_count = 0;
	int          max_len = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	logic [15:0] stall_pat = 16'h0000;
	logic [5:0]  stall_phase = 6'd0;

	siphash_128_stream_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hash_lo      (hash_lo),
		.hash_hi      (hash_hi)
	);

	function automatic logic [63:0] rotl(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic sip_state_t sip_round(sip_state_t s);
		s.v0 = s.v0 + s.v1;
		s.v1 = rotl(s.v1, 13) ^ s.v0;
		s.v0 = rotl(s.v0, 32);
		s.v2 = s.v2 + s.v3;
		s.v3 = rotl(s.v3, 16) ^ s.v2;
		s.v0 = s.v0 + s.v3;
		s.v3 = rotl(s.v3, 21) ^ s.v0;
		s.v2 = s.v2 + s.v1;
		s.v1 = rotl(s.v1, 17) ^ s.v2;
		s.v2 = rotl(s.v2, 32);
		return s;
	endfunction

	function automatic sip_state_t mix_word(sip_state_t s, logic [63:0] m);
		s.v3 = s.v3 ^ m;
		s = sip_round(sip_round(s));
		s.v0 = s.v0 ^ m;
		return s;
	endfunction

	task automatic clear_hash();
		lanes = '{v0: LANE0_INIT, v1: LANE1_INIT, v2: LANE2_INIT, v3: LANE3_INIT};
		tail_word = '0;
		msg_len = '0;
	endtask

	task automatic hash_item(input logic [7:0] b, input logic present, input logic last);
		digest_t d;
		if (present) begin
			if (msg_len[2:0] == 3'd7) begin
				lanes = mix_word(lanes, {b, tail_word});
				tail_word = '0;
			end else begin
				tail_word[msg_len[2:0] * 8 +: 8] = b;
			end
			msg_len = msg_len + 8'd1;
		end
		if (last) begin
			lanes = mix_word(lanes, {msg_len, tail_word});
			lanes.v2 = lanes.v2 ^ FINISH_XOR;
			lanes = sip_round(sip_round(sip_round(sip_round(lanes))));
			d.lo = lanes.v0 ^ lanes.v1;
			d.hi = lanes.v2 ^ lanes.v3;
			digest_q.push_back(d);
			clear_hash();
		end
	endtask

	task automatic push_item(input logic [7:0] d, input logic present, input logic last);
		stim_q.push_back('{data: d, present: present, last: last});
		if (present || last)
			load_count++;
	endtask

	task automatic push_message(input int len);
		int k;
		bit end_alone;
		end_alone = (len == 0) || ($urandom_range(0, 1) == 1);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 11) == 0)
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !end_alone);
		end
		if (end_alone)
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		if (len > max_len)
			max_len = len;
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			byte_present <= 1'b0;
			is_last <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				hash_item(data_byte, byte_present, is_last);
				tx_count++;
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (stim_q.size() > 0) begin
				drv_item = stim_q.pop_front();
				data_byte <= drv_item.data;
				byte_present <= drv_item.present;
				is_last <= drv_item.last;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_phase <= 6'd0;
			stall_pat <= 16'h0000;
		end else begin
			stall_phase <= stall_phase + 6'd1;
			out_stall <= stall_pat[stall_phase[3:0]];
			if (stall_phase == 6'd63) begin
				case ($urandom_range(0, 3))
					0: stall_pat <= 16'h0000;
					1: stall_pat <= 16'($urandom() & $urandom());
					2: stall_pat <= 16'($urandom());
					default: stall_pat <= 16'($urandom() | $urandom()) & 16'hfffe;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_digest.lo = hash_lo;
			got_digest.hi = hash_hi;
			if (digest_q.size() == 0) begin
				err_count++;
				if (err_count <= MAX_SHOWN)
					$display("unexpected digest: lo %h hi %h", hash_lo, hash_hi);
			end else begin
				want_digest = digest_q.pop_front();
				if (got_digest.lo !== want_digest.lo || got_digest.hi !== want_digest.hi) begin
					err_count++;
					if (err_count <= MAX_SHOWN)
						$display("digest %0d: expected lo %h hi %h, got lo %h hi %h",
							digests_checked, want_digest.lo, want_digest.hi,
							got_digest.lo, got_digest.hi);
				end
				digests_checked++;
			end
		end
	end

	initial begin
		bit long_done;
		clear_hash();
		long_done = 0;
		push_item(8'ha5, 1'b0, 1'b1);
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hff, 1'b1, 1'b1);
		push_item(8'h5a, 1'b0, 1'b0);
		push_item(8'h01, 1'b1, 1'b0);
		push_item(8'h80, 1'b1, 1'b0);
		push_item(8'hff, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'h7f, 1'b1, 1'b0);
		push_item(8'hfe, 1'b1, 1'b0);
		push_item(8'h55, 1'b1, 1'b0);
		push_item(8'haa, 1'b1, 1'b0);
		push_item(8'hc3, 1'b0, 1'b1);
		push_item(8'hff, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'hff, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'hff, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'hff, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b1);
		max_len = 8;
		while (load_count < ITEM_TARGET) begin
			if (!long_done && load_count >= 200) begin
				push_message($urandom_range(256, 264));
				long_done = 1;
			end else begin
				case ($urandom_range(0, 3))
					0: push_message($urandom_range(0, 3));
					1: push_message($urandom_range(6, 10));
					2: push_message($urandom_range(14, 17));
					default: push_message($urandom_range(0, 40));
				endcase
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d input transactions, %0d digests checked, longest message %0d bytes",
			tx_count, digests_checked, max_len);
		$display("%0d failures", err_count);
		if (err_count == 0 && digest_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#600000;
		$display("run timed out with %0d digests outstanding", digest_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== siphash_128_stream_top.f =====
rtl/sh128_pkg.sv
rtl/sh128_front.sv
rtl/sh128_queue.sv
rtl/sh128_back.sv
rtl/siphash_128_stream_top.sv
rtl/sh128_checker.sv
tb/testbench.sv
